/* rtl/altitude_kalman_filter_unit_defines.svh */
// Assertion macros for the altitude Kalman filter
`ifndef ALTITUDE_KALMAN_FILTER_UNIT_DEFINES_SVH
`define ALTITUDE_KALMAN_FILTER_UNIT_DEFINES_SVH
// assert that an implication holds at every clock edge outside reset
`define AKF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// assert that a condition implies another in the next cycle
`define AKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/akf_pkg.sv */
// ----------------------------------------------------------------------------
// akf_pkg
// Types and constants shared by the altitude Kalman filter.
// ----------------------------------------------------------------------------
package akf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_NOISE   = 2'd2;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_RESET  = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] measured_alt;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] altitude_est;
        logic signed [31:0] climb_est;
        logic               corrected;
        logic               saturated;
    } t_out_word;

endpackage

/* rtl/altitude_kalman_filter_unit.sv */
// ----------------------------------------------------------------------------
// altitude_kalman_filter_unit
// Two-state altitude Kalman filter, fixed point, shared multiply/divide unit.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries one word: func and measured_alt.
// func reset puts the covariance back to identity; func update predicts,
// adds process noise and, if the innovation variance is positive, corrects
// with the measured altitude. Output channel o_valid/i_stall returns one
// word per input word: altitude and climb estimates, a corrected flag and a
// saturated flag. A measurement word runs through the sequencer steps S_DT2
// to S_C1; each step issues one add, subtract, multiply or divide to the
// shared unit and stores its result. The two divides use a shift-subtract
// divider. When the innovation variance is not positive the word ends after
// S_E with the predicted covariance. A reset word goes straight to S_OUT.
// No new word is taken until the block is back in S_IDLE. While the
// receiver stalls the result holds in the output register; the block takes
// and works on the next word, which then waits in its last step with
// o_stall high until the register frees. Reset (i_rst_n low, synchronous)
// clears the estimates to zero, the covariance to identity and the registers
// to their reset values. Configuration: i_cfg_we writes i_cfg_data to
// register i_cfg_idx while idle, which the user, not the block, must ensure.
// ----------------------------------------------------------------------------
`include "altitude_kalman_filter_unit_defines.svh"

module altitude_kalman_filter_unit #(
    parameter int DATA_WIDTH = akf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = akf_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  akf_pkg::t_in_word              i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output akf_pkg::t_out_word             o_data,
    input  logic                           i_cfg_we,
    input  logic [akf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [akf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + FRAC_BITS;           // dividend bits
    localparam int CW   = $clog2(NW + 1);
    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE  = DW'(1) << FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE, S_N10T, S_DT2, S_DT3, S_DT4, S_QT, S_CDT, S_ALT, S_P11DT, S_P10DT,
        S_A01, S_DTA, S_N00A, S_SQ00, S_N00, S_SQ01, S_N01, S_N10, S_SQ11, S_N11,
        S_E, S_DIV0, S_DIV1, S_INN, S_KALT, S_KCLB, S_F, S_C2, S_C3, S_C0, S_C1,
        S_OUT, S_HOLD
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE, OP_MUL, OP_ADD, OP_SUB, OP_DIV
    } t_op;

    // configuration registers
    logic [15:0]                   r_step_time;
    logic [akf_pkg::CFG_DATA_W-1:0] r_meas_noise, r_accel_noise;

    // filter state
    logic signed [DW-1:0] r_alt, r_clb, r_p00, r_p01, r_p10, r_p11;
    // scratch
    logic signed [DW-1:0] r_meas, r_dt, r_r, r_s2, r_dt2, r_dt3, r_q00, r_q01;
    logic signed [DW-1:0] r_t, r_u, r_n00, r_n01, r_n10, r_n11, r_k0, r_k1, r_inn;
    logic                 r_clip, r_done;

    t_state r_state, n_state;
    akf_pkg::t_out_word r_out;
    logic               r_ovalid;

    // shared unit control
    logic                 r_busy;
    t_op                  r_op;
    logic signed [DW-1:0] r_a, r_b, r_res;
    logic                 r_res_clip;
    logic [1:0]           r_mstep;
    logic [PW-1:0]        r_prod;
    logic                 r_neg;
    logic [NW-1:0]        r_num;
    logic [PW:0]          r_rem;
    logic [PW-1:0]        r_q;
    logic                 r_over;
    logic [CW-1:0]        r_cnt;
    logic                 done_pulse;

    // ---------------------------------------------------------------------
    // saturation helpers
    function automatic logic signed [DW-1:0] fn_sat(input logic signed [DW+1:0] v,
                                                    output logic c);
        begin
            c = 1'b0;
            if (v > $signed({{2{VMAX[DW-1]}}, VMAX})) begin
                c = 1'b1;
                fn_sat = VMAX;
            end else if (v < $signed({{2{VMIN[DW-1]}}, VMIN})) begin
                c = 1'b1;
                fn_sat = VMIN;
            end else begin
                fn_sat = v[DW-1:0];
            end
        end
    endfunction

    function automatic logic signed [DW-1:0] fn_ssat(input logic [PW:0] m, input logic neg,
                                                     input logic over, output logic c);
        logic [PW:0] lim;
        begin
            lim = {{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}};
            c = 1'b0;
            if (neg) begin
                if (over || m > lim + 1'b1) begin
                    c = 1'b1;
                    fn_ssat = VMIN;
                end else begin
                    fn_ssat = DW'(-m);
                end
            end else if (over || m > lim) begin
                c = 1'b1;
                fn_ssat = VMAX;
            end else begin
                fn_ssat = m[DW-1:0];
            end
        end
    endfunction

    function automatic logic [DW-1:0] fn_mag(input logic signed [DW-1:0] v);
        fn_mag = v[DW-1] ? DW'(-v) : v;
    endfunction

    // ---------------------------------------------------------------------
    // shared arithmetic unit: add, sub, rounded mul, rounded div
    logic                 go;
    t_op                  go_op;
    logic signed [DW-1:0] go_a, go_b;

    always_ff @(posedge i_clk) begin
        logic signed [DW+1:0] s;
        logic [PW:0]          rnd;
        logic [PW:0]          trial;
        logic                 c;
        logic [PW:0]          qq;
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            done_pulse <= 1'b0;
        end else begin
            done_pulse <= 1'b0;
            if (go) begin
                r_op    <= go_op;
                r_a     <= go_a;
                r_b     <= go_b;
                r_neg   <= go_a[DW-1] ^ go_b[DW-1];
                r_mstep <= 2'd0;
                r_rem   <= '0;
                r_q     <= '0;
                r_over  <= 1'b0;
                r_cnt   <= CW'(NW);
                r_num   <= NW'({{DW{1'b0}}, fn_mag(go_a)}) << FRAC_BITS;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        s = (r_op == OP_ADD) ? (DW+2)'(r_a) + (DW+2)'(r_b)
                                             : (DW+2)'(r_a) - (DW+2)'(r_b);
                        r_res      <= fn_sat(s, c);
                        r_res_clip <= c;
                        r_busy     <= 1'b0;
                        done_pulse <= 1'b1;
                    end
                    OP_MUL: begin
                        if (r_mstep == 2'd0) begin
                            r_prod  <= PW'(fn_mag(r_a)) * PW'(fn_mag(r_b));
                            r_mstep <= 2'd1;
                        end else begin
                            rnd = {1'b0, r_prod} + ((PW+1)'(1) << (FRAC_BITS - 1));
                            qq  = rnd >> FRAC_BITS;
                            r_res      <= fn_ssat(qq, r_neg, 1'b0, c);
                            r_res_clip <= c;
                            r_busy     <= 1'b0;
                            done_pulse <= 1'b1;
                        end
                    end
                    OP_DIV: begin
                        if (r_cnt != '0) begin
                            trial = {r_rem[PW-1:0], r_num[NW-1]};
                            r_num <= r_num << 1;
                            if (trial >= (PW+1)'(unsigned'(r_b))) begin
                                r_rem <= trial - (PW+1)'(unsigned'(r_b));
                                if (r_cnt > CW'(PW)) r_over <= 1'b1;
                                else r_q <= {r_q[PW-2:0], 1'b1};
                            end else begin
                                r_rem <= trial;
                                if (r_cnt <= CW'(PW)) r_q <= {r_q[PW-2:0], 1'b0};
                            end
                            r_cnt <= r_cnt - 1'b1;
                        end else begin
                            qq = {1'b0, r_q};
                            if (r_rem >= (PW+1)'(unsigned'(r_b)) - r_rem) qq = qq + 1'b1;
                            r_res      <= fn_ssat(qq, r_a[DW-1], r_over | qq[PW], c);
                            r_res_clip <= c;
                            r_busy     <= 1'b0;
                            done_pulse <= 1'b1;
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // step table: which operation each state issues
    always_comb begin
        go_op = OP_NONE;
        go_a  = '0;
        go_b  = '0;
        unique case (r_state)
            S_DT2:   begin go_op = OP_MUL; go_a = r_dt;  go_b = r_dt;  end
            S_DT3:   begin go_op = OP_MUL; go_a = r_dt2; go_b = r_dt;  end
            S_DT4:   begin go_op = OP_MUL; go_a = r_dt3; go_b = r_dt;  end
            S_CDT:   begin go_op = OP_MUL; go_a = r_clb; go_b = r_dt;  end
            S_ALT:   begin go_op = OP_ADD; go_a = r_alt; go_b = r_t;   end
            S_P11DT: begin go_op = OP_MUL; go_a = r_p11; go_b = r_dt;  end
            S_P10DT: begin go_op = OP_MUL; go_a = r_p10; go_b = r_dt;  end
            S_A01:   begin go_op = OP_ADD; go_a = r_p01; go_b = r_u;   end
            S_DTA:   begin go_op = OP_MUL; go_a = r_dt;  go_b = r_n01; end
            S_N00A:  begin go_op = OP_ADD; go_a = r_p00; go_b = r_t;   end
            S_SQ00:  begin go_op = OP_ADD; go_a = r_n00; go_b = r_t;   end
            S_N00:   begin go_op = OP_MUL; go_a = r_s2;  go_b = r_q00; end
            S_SQ01:  begin go_op = OP_ADD; go_a = r_n00; go_b = r_t;   end
            S_N01:   begin go_op = OP_MUL; go_a = r_s2;  go_b = r_q01; end
            S_N10:   begin go_op = OP_ADD; go_a = r_n01; go_b = r_t;   end
            S_N10T:  begin go_op = OP_ADD; go_a = r_n10; go_b = r_t;   end
            S_SQ11:  begin go_op = OP_ADD; go_a = r_p10; go_b = r_u;   end
            S_N11:   begin go_op = OP_ADD; go_a = r_p11; go_b = r_t;   end
            S_QT:    begin go_op = OP_MUL; go_a = r_s2;  go_b = r_dt2; end
            S_E:     begin go_op = OP_ADD; go_a = r_n00; go_b = r_r;   end
            S_DIV0:  begin go_op = OP_DIV; go_a = r_n00; go_b = r_t;   end
            S_DIV1:  begin go_op = OP_DIV; go_a = r_n10; go_b = r_t;   end
            S_INN:   begin go_op = OP_SUB; go_a = r_meas; go_b = r_alt; end
            S_KALT:  begin go_op = OP_MUL; go_a = r_k0;  go_b = r_inn; end
            S_KCLB:  begin go_op = OP_MUL; go_a = r_k1;  go_b = r_inn; end
            S_F:     begin go_op = OP_SUB; go_a = ONE;   go_b = r_k0;  end
            S_C2:    begin go_op = OP_MUL; go_a = r_n00; go_b = r_k1;  end
            S_C3:    begin go_op = OP_MUL; go_a = r_n01; go_b = r_k1;  end
            S_C0:    begin go_op = OP_MUL; go_a = r_n00; go_b = r_u;   end
            S_C1:    begin go_op = OP_MUL; go_a = r_n01; go_b = r_u;   end
            default: begin go_op = OP_NONE; end
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer: sub-phase 0 issues, sub-phase 1 waits and stores
    logic r_issued;
    assign go = (go_op != OP_NONE) && !r_issued;

    // input rescaling to FRAC_BITS fraction bits
    function automatic logic signed [DW-1:0] fn_resc(input logic signed [47:0] v, input int src,
                                                     output logic c);
        logic signed [DW+48:0] w;
        begin
            if (FRAC_BITS >= src) w = (DW+49)'(v) <<< (FRAC_BITS - src);
            else w = (DW+49)'(v) >>> (src - FRAC_BITS);
            c = 1'b0;
            if (w > (DW+49)'(VMAX)) begin
                c = 1'b1;
                fn_resc = VMAX;
            end else if (w < (DW+49)'(VMIN)) begin
                c = 1'b1;
                fn_resc = VMIN;
            end else begin
                fn_resc = w[DW-1:0];
            end
        end
    endfunction

    // clip to the 32-bit output field
    function automatic logic signed [31:0] fn_o32(input logic signed [DW-1:0] v, output logic c);
        logic signed [DW+32:0] w;
        begin
            w = (DW+33)'(v);
            c = 1'b0;
            if (w > (DW+33)'(32'sh7fffffff)) begin
                c = 1'b1;
                fn_o32 = 32'sh7fffffff;
            end else if (w < -(DW+33)'(33'sh080000000)) begin
                c = 1'b1;
                fn_o32 = 32'sh80000000;
            end else begin
                fn_o32 = w[31:0];
            end
        end
    endfunction

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        logic c0, c1, c2, c3;
        logic cx;
        logic signed [DW-1:0] v0, v1, v2, v3;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_issued      <= 1'b0;
            r_ovalid      <= 1'b0;
            r_step_time   <= 16'd16384;
            r_meas_noise  <= akf_pkg::CFG_DATA_W'(131072);
            r_accel_noise <= akf_pkg::CFG_DATA_W'(65536);
            r_alt <= '0;
            r_clb <= '0;
            r_p00 <= ONE;
            r_p01 <= '0;
            r_p10 <= '0;
            r_p11 <= ONE;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    akf_pkg::REG_STEP_TIME:     r_step_time   <= i_cfg_data[15:0];
                    akf_pkg::REG_MEASURE_NOISE: r_meas_noise  <= i_cfg_data;
                    akf_pkg::REG_ACCEL_NOISE:   r_accel_noise <= i_cfg_data;
                    default: ;
                endcase
            end
            // output register: loaded from S_OUT once free, cleared when taken
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (go) r_issued <= 1'b1;

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_done <= 1'b0;
                        if (i_data.func == akf_pkg::FUNC_RESET) begin
                            r_clip <= 1'b0;
                            r_p00 <= ONE;
                            r_p01 <= '0;
                            r_p10 <= '0;
                            r_p11 <= ONE;
                            r_state <= S_OUT;
                        end else begin
                            v0 = fn_resc(48'(i_data.measured_alt), 16, c0);
                            v1 = fn_resc(48'({1'b0, r_step_time}), 16, c1);
                            v2 = fn_resc(48'({1'b0, r_meas_noise}), FRAC_BITS, c2);
                            v3 = fn_resc(48'({1'b0, r_accel_noise}), FRAC_BITS, c3);
                            r_meas <= v0;
                            r_dt   <= v1;
                            r_r    <= v2;
                            r_s2   <= v3;
                            r_clip <= c0 | c1 | c2 | c3;
                            r_state <= S_DT2;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out.altitude_est <= fn_o32(r_alt, c0);
                        r_out.climb_est    <= fn_o32(r_clb, c1);
                        r_out.corrected    <= r_done;
                        r_out.saturated    <= r_clip | c0 | c1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    if (done_pulse) begin
                        r_issued <= 1'b0;
                        cx = 1'b0;
                        unique case (r_state)
                            S_DT2:   begin r_dt2 <= r_res; r_state <= S_DT3; end
                            S_DT3:   begin
                                r_dt3 <= r_res;
                                r_q01 <= r_res >>> 1;
                                r_state <= S_DT4;
                            end
                            S_DT4:   begin r_q00 <= r_res >>> 2; r_state <= S_QT; end
                            // s2*dt^2 kept in n11 until n11 is formed
                            S_QT:    begin r_n11 <= r_res; r_state <= S_CDT; end
                            S_CDT:   begin r_t <= r_res; r_state <= S_ALT; end
                            S_ALT:   begin r_alt <= r_res; r_state <= S_P11DT; end
                            S_P11DT: begin r_u <= r_res; r_state <= S_P10DT; end
                            S_P10DT: begin r_t <= r_res; r_state <= S_A01; end
                            // n01 temporarily holds p01 + p11*dt
                            S_A01:   begin r_n01 <= r_res; r_state <= S_N00A; end
                            S_N00A:  begin r_n00 <= r_res; r_state <= S_DTA; end
                            S_DTA:   begin r_t <= r_res; r_state <= S_SQ01; end
                            S_SQ01:  begin r_n00 <= r_res; r_state <= S_N00; end
                            S_N00:   begin r_t <= r_res; r_state <= S_SQ00; end
                            S_SQ00:  begin
                                r_n00 <= r_res;
                                r_t   <= r_n11;
                                r_state <= S_N11;
                            end
                            S_N11:   begin r_n11 <= r_res; r_state <= S_N01; end
                            S_N01:   begin r_t <= r_res; r_state <= S_SQ11; end
                            S_SQ11:  begin r_n10 <= r_res; r_state <= S_N10; end
                            S_N10:   begin r_n01 <= r_res; r_state <= S_N10T; end
                            S_N10T:  begin r_n10 <= r_res; r_state <= S_E; end
                            S_E:     begin
                                r_t <= r_res;
                                if (r_res > 0) r_state <= S_DIV0;
                                else begin
                                    r_p00 <= r_n00;
                                    r_p01 <= r_n01;
                                    r_p10 <= r_n10;
                                    r_p11 <= r_n11;
                                    r_state <= S_OUT;
                                end
                            end
                            S_DIV0:  begin r_k0 <= r_res; r_state <= S_DIV1; end
                            S_DIV1:  begin r_k1 <= r_res; r_state <= S_INN; end
                            S_INN:   begin r_inn <= r_res; r_state <= S_KALT; end
                            S_KALT:  begin r_u <= r_res; r_state <= S_KCLB; end
                            S_KCLB:  begin
                                r_alt <= fn_sat((DW+2)'(r_alt) + (DW+2)'(r_u), c0);
                                r_clb <= fn_sat((DW+2)'(r_clb) + (DW+2)'(r_res), c1);
                                cx = c0 | c1;
                                r_state <= S_F;
                            end
                            S_F:     begin r_u <= r_res; r_state <= S_C2; end
                            S_C2:    begin
                                r_p10 <= fn_sat((DW+2)'(r_n10) - (DW+2)'(r_res), c0);
                                cx = c0;
                                r_state <= S_C3;
                            end
                            S_C3:    begin
                                r_p11 <= fn_sat((DW+2)'(r_n11) - (DW+2)'(r_res), c0);
                                cx = c0;
                                r_state <= S_C0;
                            end
                            S_C0:    begin r_p00 <= r_res; r_state <= S_C1; end
                            S_C1:    begin
                                r_p01 <= r_res;
                                r_done <= 1'b1;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                        r_clip <= r_clip | r_res_clip | cx;
                    end
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // checks
    `AKF_ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_stall,
        "input taken while an item is in progress")
    `AKF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data),
        "result changed while stalled")
    `AKF_ASSERT_IMPL(a_one_issue, i_clk, i_rst_n, r_busy, !go,
        "shared unit restarted while busy")

endmodule
